// File: hdl/sktt_pkg.sv
// Package of the subtitle karaoke tag tokenizer: result kinds, character codes,
// the result record and the command and status records between controller and datapath.
// Depends on nothing; every other file of the block but sktt_ram imports it.
package sktt_pkg;

    localparam int SKTT_TAG_DEPTH = 32;
    localparam int SKTT_TDATA_W   = 48;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_KARA   = 2'd1,
        KIND_EFFECT = 2'd2,
        KIND_EOL    = 2'd3
    } t_kind;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_K_LO   = 8'h6B;
    localparam logic [7:0] CH_K_UP   = 8'h4B;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  text_char;
        logic        token_start;
        logic [31:0] duration_ms;
        logic        last;
    } t_res;

    // Commands from the controller to the datapath for the current cycle.
    typedef struct packed {
        logic  use_held;    // work on the held character instead of the input
        logic  push;        // write one result into the output queue
        logic  push_ram;    // result character comes from the pending buffer
        t_kind push_kind;
        logic  push_last;
        logic  store;       // append the character to the pending buffer
        logic  store_first; // restart the buffer with this character
        logic  clr_tag;     // drop the pending bytes and the count
        logic  acc_zero;
        logic  acc_digit;
        logic  open_clr;
        logic  hold_ch;
        logic  rd_start;
        logic  rd_step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_zero;
        logic is_lbrace;
        logic is_rbrace;
        logic is_bslash;
        logic is_k;
        logic is_of;
        logic full;
        logic rd_last;
        logic out_room;
    } t_sts;

endpackage

// File: hdl/subtitle_karaoke_tag_tokenizer.sv
// Subtitle karaoke tag tokenizer, top level: controller plus datapath.
// Depends on sktt_pkg, sktt_ctrl, sktt_dp and sktt_ram.
//
// The block takes one byte of a subtitle event line per request on the slave
// stream and sorts the bytes into text characters, karaoke tags ({\k..}, {\K..},
// with an optional o or f) and other override tags; a zero byte ends the line.
// Ordinary text bytes and tag bytes are taken at one per cycle while the output
// queue has room. Bytes of an open tag wait in a pending buffer of TAG_DEPTH bytes
// held in a RAM with one read port. When a tag fails (the line ends inside it,
// a brace is not followed by a backslash, or the buffer is full) its n pending
// bytes are replayed as text at one byte per cycle, while the output queue has
// room, through that read port; then the byte that caused the replay is handled,
// and input is held off from the failure until that byte has been
// handled. Results leave through
// an output register with a skid entry behind it, so an input request is still
// taken while one result waits on the master stream; a longer stall on the
// master side holds the input. A karaoke tag reports its digits times 10 ms,
// saturating at 2^32-1. The pending buffer needs no clearing after reset.
module subtitle_karaoke_tag_tokenizer #(
    parameter int TAG_DEPTH = sktt_pkg::SKTT_TAG_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream, one request per byte of event text.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    // Master stream, one request per result.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] text_char, [8] token_start,
                                          // [40:9] duration_ms, [47:41] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last result caused by the input byte
);
    import sktt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_res res;

    sktt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_s_axis_tvalid),
        .o_in_ready(o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    sktt_dp #(.TAG_DEPTH(TAG_DEPTH)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (i_s_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (res),
        .o_res_valid(o_m_axis_tvalid),
        .i_res_ready(i_m_axis_tready)
    );

    // Pack the result fields, lowest field first, padded to whole bytes.
    assign o_m_axis_tdata = {7'd0, res.duration_ms, res.token_start, res.text_char};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

// File: hdl/sktt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sktt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/sktt_ctrl.sv
// Controller of the tokenizer: parse mode and the replay sequencer.
// Depends on sktt_pkg; drives the datapath through t_cmd and reads t_sts.
module sktt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sktt_pkg::t_sts i_sts,
    output sktt_pkg::t_cmd o_cmd
);
    import sktt_pkg::*;

    typedef enum logic [2:0] {
        M_TEXT, M_BRACE, M_BSLASH, M_KOPT, M_KDIG, M_EFFECT
    } t_mode;

    typedef enum logic [1:0] {
        P_RUN, P_REPLAY, P_TAIL
    } t_phase;

    t_mode  r_mode, n_mode;
    t_phase r_phase, n_phase;
    t_cmd   cmd;
    logic   accept;
    logic   body;
    logic   kara;

    assign o_in_ready = (r_phase == P_RUN) && i_sts.out_room;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        cmd       = '0;
        cmd.push_kind = KIND_TEXT;
        cmd.use_held  = (r_phase != P_RUN);
        n_mode    = r_mode;
        n_phase   = r_phase;
        body      = 1'b0;
        kara      = 1'b0;
        case (r_phase)
            P_RUN: begin
                if (accept) begin
                    case (r_mode)
                        M_BRACE: begin
                            if (i_sts.is_bslash) begin
                                cmd.store = 1'b1;
                                n_mode    = M_BSLASH;
                            end else begin
                                cmd.hold_ch  = 1'b1;
                                cmd.rd_start = 1'b1;
                                n_phase      = P_REPLAY;
                            end
                        end
                        M_BSLASH: begin
                            if (i_sts.is_zero) begin
                                cmd.hold_ch  = 1'b1;
                                cmd.rd_start = 1'b1;
                                n_phase      = P_REPLAY;
                            end else if (i_sts.is_k) begin
                                cmd.acc_zero = 1'b1;
                                cmd.store    = 1'b1;
                                n_mode       = M_KOPT;
                            end else if (i_sts.is_rbrace) begin
                                cmd.push      = 1'b1;
                                cmd.push_kind = KIND_EFFECT;
                                cmd.push_last = 1'b1;
                                cmd.clr_tag   = 1'b1;
                                cmd.open_clr  = 1'b1;
                                n_mode        = M_TEXT;
                            end else begin
                                cmd.store = 1'b1;
                                n_mode    = M_EFFECT;
                            end
                        end
                        M_KOPT: begin
                            n_mode = M_KDIG;
                            if (i_sts.is_of) begin
                                cmd.store = 1'b1;
                            end else begin
                                body = 1'b1;
                                kara = 1'b1;
                            end
                        end
                        M_KDIG: begin
                            body = 1'b1;
                            kara = 1'b1;
                        end
                        M_EFFECT: begin
                            body = 1'b1;
                        end
                        default: begin
                            n_mode = M_TEXT;
                            if (i_sts.is_zero) begin
                                cmd.push      = 1'b1;
                                cmd.push_kind = KIND_EOL;
                                cmd.push_last = 1'b1;
                                cmd.clr_tag   = 1'b1;
                                cmd.open_clr  = 1'b1;
                            end else if (i_sts.is_lbrace) begin
                                cmd.store_first = 1'b1;
                                n_mode          = M_BRACE;
                            end else begin
                                cmd.push      = 1'b1;
                                cmd.push_last = 1'b1;
                            end
                        end
                    endcase
                    // Shared handling of a byte inside the body of a tag.
                    if (body) begin
                        if (i_sts.is_zero || (!i_sts.is_rbrace && i_sts.full)) begin
                            cmd.hold_ch  = 1'b1;
                            cmd.rd_start = 1'b1;
                            n_phase      = P_REPLAY;
                        end else if (i_sts.is_rbrace) begin
                            cmd.push      = 1'b1;
                            cmd.push_kind = kara ? KIND_KARA : KIND_EFFECT;
                            cmd.push_last = 1'b1;
                            cmd.clr_tag   = 1'b1;
                            cmd.open_clr  = 1'b1;
                            n_mode        = M_TEXT;
                        end else begin
                            cmd.acc_digit = kara;
                            cmd.store     = 1'b1;
                        end
                    end
                end
            end
            P_REPLAY: begin
                if (i_sts.out_room) begin
                    cmd.push      = 1'b1;
                    cmd.push_ram  = 1'b1;
                    cmd.rd_step   = 1'b1;
                    // The held brace produces no result, so the last replayed byte closes.
                    cmd.push_last = i_sts.is_lbrace && i_sts.rd_last;
                    if (i_sts.rd_last) begin
                        cmd.clr_tag = 1'b1;
                        n_mode      = M_TEXT;
                        n_phase     = P_TAIL;
                    end
                end
            end
            P_TAIL: begin
                if (i_sts.is_lbrace) begin
                    cmd.store_first = 1'b1;
                    n_mode          = M_BRACE;
                    n_phase         = P_RUN;
                end else if (i_sts.out_room) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    n_phase       = P_RUN;
                    if (i_sts.is_zero) begin
                        cmd.push_kind = KIND_EOL;
                        cmd.clr_tag   = 1'b1;
                        cmd.open_clr  = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = P_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_TEXT;
            r_phase <= P_RUN;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
        end
    end

    assign o_cmd = cmd;

endmodule

// File: hdl/sktt_dp.sv
// Datapath of the tokenizer: duration accumulator, pending buffer with its count
// and read index, token state and a two-entry output queue. Depends on sktt_pkg, sktt_ram.
module sktt_dp #(
    parameter int TAG_DEPTH = sktt_pkg::SKTT_TAG_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_ch,
    input  sktt_pkg::t_cmd i_cmd,
    output sktt_pkg::t_sts o_sts,
    output sktt_pkg::t_res o_res,
    output logic           o_res_valid,
    input  logic           i_res_ready
);
    import sktt_pkg::*;

    localparam int CW = $clog2(TAG_DEPTH + 1);
    localparam int AW = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;

    logic [31:0]   r_acc;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_open;
    logic [7:0]    r_ch;
    t_res          r_hd, r_sk, res;
    logic          r_hd_valid, r_sk_valid;

    logic [7:0]    cur;
    logic          is_digit;
    logic [3:0]    dig;
    logic [35:0]   mac;
    logic [31:0]   sat;
    logic [7:0]    q;
    logic [7:0]    pch;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic          pop;

    assign cur      = i_cmd.use_held ? r_ch : i_ch;
    assign is_digit = (cur >= CH_ZERO) && (cur <= CH_NINE);
    assign dig      = is_digit ? 4'(cur - CH_ZERO) : 4'd0;

    // acc * 10 + digit, saturated to 32 bits.
    assign mac = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + {32'd0, dig};
    assign sat = (|mac[35:32]) ? 32'hFFFF_FFFF : mac[31:0];

    assign we    = i_cmd.store || i_cmd.store_first;
    assign waddr = i_cmd.store_first ? '0 : r_cnt[AW-1:0];

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.rd_start) begin
            n_idx = '0;
        end else if (i_cmd.rd_step) begin
            n_idx = r_idx + CW'(1);
        end
    end

    // The RAM is read at the next index, so its output shows the current one while that lies inside the buffer.
    assign raddr = (n_idx < CW'(TAG_DEPTH)) ? n_idx[AW-1:0] : '0;

    sktt_ram #(.WIDTH(8), .DEPTH(TAG_DEPTH)) u_pending (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(cur),
        .i_raddr(raddr),
        .o_rdata(q)
    );

    assign pch = i_cmd.push_ram ? q : cur;

    always_comb begin
        res.kind        = i_cmd.push_kind;
        res.last        = i_cmd.push_last;
        res.text_char   = (i_cmd.push_kind == KIND_TEXT) ? pch : 8'd0;
        res.token_start = (i_cmd.push_kind == KIND_TEXT) && ((pch == CH_LBRACE) || !r_open);
        res.duration_ms = (i_cmd.push_kind == KIND_KARA) ? sat : 32'd0;
    end

    assign pop = r_hd_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_cnt      <= '0;
            r_idx      <= '0;
            r_open     <= 1'b0;
            r_hd_valid <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;

            if (i_cmd.clr_tag || i_cmd.acc_zero) begin
                r_acc <= '0;
            end else if (i_cmd.acc_digit && is_digit) begin
                r_acc <= sat;
            end

            if (i_cmd.store_first) begin
                r_cnt <= CW'(1);
            end else if (i_cmd.clr_tag) begin
                r_cnt <= '0;
            end else if (i_cmd.store) begin
                r_cnt <= r_cnt + CW'(1);
            end

            if (i_cmd.open_clr) begin
                r_open <= 1'b0;
            end else if (i_cmd.push && (i_cmd.push_kind == KIND_TEXT)) begin
                r_open <= 1'b1;
            end

            // A push is only commanded while the skid entry is empty.
            if (pop) begin
                if (r_sk_valid) begin
                    r_hd       <= r_sk;
                    r_sk_valid <= 1'b0;
                end else begin
                    r_hd_valid <= i_cmd.push;
                    r_hd       <= res;
                end
            end else if (i_cmd.push) begin
                if (!r_hd_valid) begin
                    r_hd_valid <= 1'b1;
                    r_hd       <= res;
                end else begin
                    r_sk_valid <= 1'b1;
                    r_sk       <= res;
                end
            end
        end
        if (i_cmd.hold_ch) begin
            r_ch <= i_ch;
        end
    end

    always_comb begin
        o_sts.is_zero   = (cur == CH_NUL);
        o_sts.is_lbrace = (cur == CH_LBRACE);
        o_sts.is_rbrace = (cur == CH_RBRACE);
        o_sts.is_bslash = (cur == CH_BSLASH);
        o_sts.is_k      = (cur == CH_K_LO) || (cur == CH_K_UP);
        o_sts.is_of     = (cur == CH_O) || (cur == CH_F);
        o_sts.full      = (r_cnt >= CW'(TAG_DEPTH));
        o_sts.rd_last   = (r_idx == (r_cnt - CW'(1)));
        o_sts.out_room  = !r_sk_valid;
    end

    assign o_res       = r_hd;
    assign o_res_valid = r_hd_valid;

endmodule

// File: hdl/sktt_checker.sv
// Checker for the tokenizer ports, attached to the top level by the bind below.
// Depends on sktt_pkg and subtitle_karaoke_tag_tokenizer.
module sktt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import sktt_pkg::*;

    // Reset empties the output queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result shown right after reset");

    // Only text results carry a character and a token start.
    a_text_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != KIND_TEXT)) |-> (o_m_axis_tdata[8:0] == 9'd0))
        else $error("character field set on a non-text result");

    // Only karaoke results carry a duration.
    a_dur_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != KIND_KARA)) |-> (o_m_axis_tdata[40:9] == 32'd0))
        else $error("duration set on a non-karaoke result");

    // End of line is always the final result of its byte.
    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_EOL)) |-> o_m_axis_tlast)
        else $error("end of line without tlast");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
         && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind subtitle_karaoke_tag_tokenizer sktt_checker u_sktt_checker (.*);

// File: dv/sktt_token_checker.sv
// Checker of the subtitle karaoke tag tokenizer: watches both streams, predicts the
// tokens of every accepted byte and compares them with the results on the master side.
// Depends on sktt_pkg for the result record, the kind codes and the character codes.
module sktt_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] ch
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,   // [7:0] text_char, [8] token_start, [40:9] duration_ms
    input  logic [1:0]  i_m_tuser,   // [1:0] kind
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import sktt_pkg::*;

    typedef enum logic [2:0] {
        SCAN_TEXT,
        SCAN_BRACE,
        SCAN_BSLASH,
        SCAN_KOPT,
        SCAN_KDIGIT,
        SCAN_EFFECT
    } t_scan;

    t_scan       scan_mode;
    logic [7:0]  pending_buf [SKTT_TAG_DEPTH];
    int          pending_len;
    logic [31:0] centis;
    logic        token_open;
    t_res        step_tokens[$];
    t_res        expected_tokens[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("checker: %0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    // Decimal shift-in with saturation at the top of 32 bits.
    function automatic logic [31:0] times_ten_plus(input logic [31:0] acc,
                                                   input logic [3:0] digit);
        logic [35:0] wide;
        wide = {4'd0, acc} * 36'd10 + {32'd0, digit};
        return (wide > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    task automatic put_token(input t_kind kind, input logic [7:0] c, input logic start,
                             input logic [31:0] dur);
        t_res tok;
        tok.kind        = kind;
        tok.text_char   = c;
        tok.token_start = start;
        tok.duration_ms = dur;
        tok.last        = 1'b0;
        step_tokens.push_back(tok);
    endtask

    task automatic emit_text(input logic [7:0] c, input logic forced);
        put_token(KIND_TEXT, c, forced || !token_open, 32'd0);
        token_open = 1'b1;
    endtask

    task automatic replay_pending();
        for (int i = 0; i < pending_len; i++)
            emit_text(pending_buf[i], pending_buf[i] == CH_LBRACE);
        pending_len = 0;
        centis      = '0;
        scan_mode   = SCAN_TEXT;
    endtask

    task automatic end_of_line();
        put_token(KIND_EOL, 8'd0, 1'b0, 32'd0);
        pending_len = 0;
        centis      = '0;
        scan_mode   = SCAN_TEXT;
        token_open  = 1'b0;
    endtask

    task automatic text_byte(input logic [7:0] c);
        if (c == CH_NUL) begin
            end_of_line();
        end else if (c == CH_LBRACE) begin
            pending_buf[0] = c;
            pending_len    = 1;
            scan_mode      = SCAN_BRACE;
        end else begin
            emit_text(c, 1'b0);
        end
    endtask

    // A byte that finds the buffer full flushes it and starts over in text mode.
    task automatic hold_byte(input logic [7:0] c);
        if (pending_len >= SKTT_TAG_DEPTH) begin
            replay_pending();
            text_byte(c);
        end else begin
            pending_buf[pending_len] = c;
            pending_len++;
        end
    endtask

    task automatic close_tag(input t_kind kind, input logic [31:0] dur);
        put_token(kind, 8'd0, 1'b0, dur);
        pending_len = 0;
        centis      = '0;
        token_open  = 1'b0;
        scan_mode   = SCAN_TEXT;
    endtask

    task automatic tag_byte(input logic [7:0] c, input logic karaoke);
        if (c == CH_NUL) begin
            replay_pending();
            end_of_line();
        end else if (c == CH_RBRACE) begin
            if (karaoke)
                close_tag(KIND_KARA, times_ten_plus(centis, 4'd0));
            else
                close_tag(KIND_EFFECT, 32'd0);
        end else begin
            if (karaoke && c >= CH_ZERO && c <= CH_NINE)
                centis = times_ten_plus(centis, 4'(c - CH_ZERO));
            hold_byte(c);
        end
    endtask

    task automatic predict_tokens(input logic [7:0] c);
        t_res tail;
        case (scan_mode)
            SCAN_BRACE: begin
                if (c == CH_BSLASH) begin
                    scan_mode = SCAN_BSLASH;
                    hold_byte(c);
                end else begin
                    replay_pending();
                    text_byte(c);
                end
            end
            SCAN_BSLASH: begin
                if (c == CH_NUL) begin
                    replay_pending();
                    end_of_line();
                end else if (c == CH_K_LO || c == CH_K_UP) begin
                    centis    = '0;
                    scan_mode = SCAN_KOPT;
                    hold_byte(c);
                end else if (c == CH_RBRACE) begin
                    close_tag(KIND_EFFECT, 32'd0);
                end else begin
                    scan_mode = SCAN_EFFECT;
                    hold_byte(c);
                end
            end
            SCAN_KOPT: begin
                scan_mode = SCAN_KDIGIT;
                if (c == CH_O || c == CH_F)
                    hold_byte(c);
                else
                    tag_byte(c, 1'b1);
            end
            SCAN_KDIGIT: tag_byte(c, 1'b1);
            SCAN_EFFECT: tag_byte(c, 1'b0);
            default: begin
                scan_mode = SCAN_TEXT;
                text_byte(c);
            end
        endcase
        if (step_tokens.size() > 0) begin
            tail      = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.push_back(tail);
        end
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
        step_tokens.delete();
    endtask

    always @(posedge i_clk) begin : monitor
        t_res want;
        if (!i_rst_n) begin
            scan_mode   = SCAN_TEXT;
            pending_len = 0;
            centis      = '0;
            token_open  = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("result kind %0d with nothing expected",
                                              i_m_tuser));
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_m_tuser != want.kind)
                        report_mismatch($sformatf("kind got %0d expected %0d",
                                                  i_m_tuser, want.kind));
                    if (i_m_tdata[7:0] != want.text_char)
                        report_mismatch($sformatf("text_char got %02h expected %02h",
                                                  i_m_tdata[7:0], want.text_char));
                    if (i_m_tdata[8] != want.token_start)
                        report_mismatch($sformatf("token_start got %0d expected %0d",
                                                  i_m_tdata[8], want.token_start));
                    if (i_m_tdata[40:9] != want.duration_ms)
                        report_mismatch($sformatf("duration_ms got %0d expected %0d",
                                                  i_m_tdata[40:9], want.duration_ms));
                    if (i_m_tlast != want.last)
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  i_m_tlast, want.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predict_tokens(i_s_tdata);
        end
        o_waiting <= expected_tokens.size();
    end

endmodule

// File: dv/testbench.sv
// Top of the tokenizer testbench: clock, reset, byte stimulus, output back-pressure
// and the verdict. Depends on sktt_pkg, sktt_token_checker and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sktt_pkg::*;

    // Cycles without any accepted request before the run is declared hung. The
    // slowest correct stretch is a sender gap plus a receiver stall plus a replay
    // of a full buffer.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 350;

    // Directed line: text up to the top byte value, a brace that is not a tag, the
    // empty effect, a karaoke tag with an option and a skipped non-digit, an
    // ordinary effect, and a karaoke tag cut short by the end of the line.
    localparam logic [7:0] DIRECTED [24] = '{
        8'h41, 8'hFF, CH_LBRACE, 8'h78,
        CH_LBRACE, CH_BSLASH, CH_RBRACE,
        CH_LBRACE, CH_BSLASH, CH_K_LO, CH_F, 8'h31, 8'h7A, 8'h32, CH_RBRACE,
        CH_LBRACE, CH_BSLASH, 8'h69, 8'h31, CH_RBRACE,
        CH_LBRACE, CH_BSLASH, CH_K_UP, CH_NUL
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] ch
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [47:0] o_m_axis_tdata;   // [7:0] text_char, [8] token_start, [40:9] duration_ms
    logic [1:0]  o_m_axis_tuser;   // [1:0] kind
    logic        o_m_axis_tlast;

    int fail_count;
    int tokens_waiting;
    int sent        = 0;
    int quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    subtitle_karaoke_tag_tokenizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    sktt_token_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .i_m_tlast    (o_m_axis_tlast),
        .o_fail_count (fail_count),
        .o_waiting    (tokens_waiting)
    );

    // Idling is allowed on both sides except in a quiet window in the middle of
    // the random part and throughout its final stretch.
    function automatic bit idling_allowed();
        return !(sent >= 120 && sent < 160) && sent < RANDOM_ITEMS - 60;
    endfunction

    // Presents one byte and returns at the edge where its request is taken. It is
    // always entered at a rising edge, so valid is never lowered and raised in
    // the same step: a gap lowers it, and only then is it raised again.
    task automatic send_byte(input logic [7:0] ch);
        if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        sent++;
    endtask

    // A run of plain text: any non-zero byte except the opening brace.
    task automatic send_text_run(input int len);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            do
                b = 8'($urandom_range(1, 255));
            while (b == CH_LBRACE);
            send_byte(b);
        end
    endtask

    // Any byte that may sit inside a tag body without closing it or the line.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_RBRACE);
        return b;
    endfunction

    // Back-pressure on the result stream: random stalls, where idling is allowed,
    // between ready stretches of random length.
    initial begin
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idling_allowed() && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    // Hang detector: any accepted request on either stream restarts the count.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         pick;
        int         len;
        logic [7:0] b;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= 8'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);

        // Random part: well-formed tags with random content, plus text,
        // line ends, braces that fail, buffer overflows and raw noise.
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                // Karaoke tag; now and then long enough in digits to saturate.
                send_byte(CH_LBRACE);
                send_byte(CH_BSLASH);
                send_byte($urandom_range(0, 1) ? CH_K_LO : CH_K_UP);
                case ($urandom_range(0, 2))
                    0: send_byte(CH_O);
                    1: send_byte(CH_F);
                    default: ;
                endcase
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14)
                                                  : $urandom_range(0, 4);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0)
                        b = body_byte();
                    else
                        b = CH_ZERO + 8'($urandom_range(0, 9));
                    send_byte(b);
                end
                case ($urandom_range(0, 9))
                    8: send_byte(CH_NUL);
                    9: ;
                    default: send_byte(CH_RBRACE);
                endcase
            end else if (pick < 45) begin
                // Other override tag, possibly empty.
                send_byte(CH_LBRACE);
                send_byte(CH_BSLASH);
                len = $urandom_range(0, 5);
                for (int k = 0; k < len; k++)
                    send_byte(body_byte());
                send_byte(($urandom_range(0, 7) == 0) ? CH_NUL : CH_RBRACE);
            end else if (pick < 65) begin
                send_text_run($urandom_range(1, 6));
            end else if (pick < 73) begin
                send_byte(CH_NUL);
            end else if (pick < 78) begin
                // A brace followed by anything; only a backslash keeps the tag.
                send_byte(CH_LBRACE);
                b = 8'($urandom_range(0, 255));
                send_byte(b);
            end else if (pick < 82) begin
                // A tag body around the buffer depth: one byte short of full, exactly
                // full, or one or more bytes past it.
                send_byte(CH_LBRACE);
                send_byte(CH_BSLASH);
                send_byte($urandom_range(0, 1) ? CH_K_LO : 8'h62);
                len = $urandom_range(28, 34);
                for (int k = 0; k < len; k++) begin
                    b = CH_ZERO + 8'($urandom_range(0, 9));
                    send_byte(b);
                end
                send_byte(CH_RBRACE);
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b);
                end
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Let the checker see the last request before looking at what is left,
        // then drain and give stray results time to show up.
        @(posedge i_clk);
        while (tokens_waiting != 0)
            @(posedge i_clk);
        repeat (2 * SKTT_TAG_DEPTH) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
